/* hw/rtl/asc_pkg.sv */
// shared types and constants of the step counter
`default_nettype none

package asc_pkg;

  localparam int AXIS_W     = 13;
  localparam int LEVEL_W    = 13;
  localparam int TOTAL_W    = 16;
  localparam int DEADBAND_W = 13;
  localparam int REFR_W     = 12;
  localparam int PERIOD_W   = 8;
  localparam int WSU_W      = 8;

  localparam int RAD_W      = 2 * AXIS_W;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_CNT_W = 4;
  localparam int REM_W      = LEVEL_W + 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd2;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = 13'd100;
  localparam logic [REFR_W-1:0]     REFRACTORY_RESET = 12'd200;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET     = 8'd51;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QFILL_W     = 2;

  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband;
    logic [REFR_W-1:0]     refractory_ticks;
    logic [PERIOD_W-1:0]   update_period;
  } cfg_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/asc_if.sv */
// sample and result channel interfaces
`default_nettype none

interface asc_sample_if;
  import asc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, opcode, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, opcode, accel_x, accel_y, accel_z, output ready);
endinterface

interface asc_result_if;
  import asc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] step_total;
  logic               step_now;
  logic               window_done;
  logic [LEVEL_W-1:0] held_level;
  logic [LEVEL_W-1:0] step_threshold;

  modport source (output valid, step_total, step_now, window_done, held_level,
                  step_threshold, input ready);
  modport sink (input valid, step_total, step_now, window_done, held_level,
                step_threshold, output ready);
endinterface

`default_nettype wire

/* hw/rtl/asc_front.sv */
// input side: beat acceptance and a two-entry item queue
`default_nettype none

module asc_front (
  input  logic          clk,
  input  logic          rst,
  asc_sample_if.sink    samples,
  output logic          q_valid,
  input  logic          q_ready,
  output asc_pkg::item_t q_item
);
  import asc_pkg::*;

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  logic               pop;

  assign samples.ready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign push          = samples.valid && samples.ready;
  assign q_valid       = (fill != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{opcode:  samples.opcode,
                         accel_x: samples.accel_x,
                         accel_y: samples.accel_y,
                         accel_z: samples.accel_z};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/asc_back.sv */
// execution side: squares, bit-serial root, window average and step logic
`default_nettype none

module asc_back #(
  parameter int WINDOW     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  asc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  asc_pkg::item_t q_item,
  asc_result_if.source   results
);
  import asc_pkg::*;

  localparam int DIVL    = $clog2(WINDOW);
  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = LEVEL_W + DIVL;
  localparam int SHIFT   = SUM_W + DIVL;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + WINDOW - 1) / WINDOW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_LEVEL  = 3'd4;
  localparam logic [2:0] ST_TRACK  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]               state;
  logic [1:0]               axis_sel;
  logic [ROOT_CNT_W-1:0]    root_cnt;
  logic signed [AXIS_W-1:0] ax_x;
  logic signed [AXIS_W-1:0] ax_y;
  logic signed [AXIS_W-1:0] ax_z;
  logic [RAD_W-1:0]         rad;
  logic [REM_W-1:0]         rem;
  logic [LEVEL_W-1:0]       root;
  logic [PROD_W-1:0]        prod;

  logic [SUM_W-1:0]      window_sum;
  logic [IDX_W-1:0]      window_index;
  logic [LEVEL_W-1:0]    level_held;
  logic [LEVEL_W-1:0]    level_max;
  logic [LEVEL_W-1:0]    level_min;
  logic [LEVEL_W-1:0]    threshold_value;
  logic [REFR_W-1:0]     refractory_left;
  logic [WSU_W-1:0]      windows_since_update;
  logic [COUNT_BITS-1:0] step_counter;
  logic                  step_now;
  logic                  window_done;
  logic                  track_due;

  logic signed [AXIS_W-1:0] axis_val;
  logic signed [RAD_W-1:0]  square;
  logic [REM_W-1:0]         rem_shift;
  logic [REM_W-1:0]         trial;
  logic                     rem_ok;
  logic [SUM_W-1:0]         sum_total;
  logic [LEVEL_W-1:0]       avg;
  logic [LEVEL_W-1:0]       diff;
  logic                     level_update;
  logic                     step_hit;
  logic [WSU_W-1:0]         wsu_inc;
  logic [LEVEL_W-1:0]       new_max;
  logic [LEVEL_W-1:0]       new_min;
  logic [LEVEL_W:0]         mid_sum;
  logic [31:0]              cnt_ext;

  always_comb begin
    case (axis_sel)
      2'd0:    axis_val = ax_x;
      2'd1:    axis_val = ax_y;
      default: axis_val = ax_z;
    endcase
  end

  assign square    = axis_val * axis_val;
  assign rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = REM_W'({root, 2'b01});
  assign rem_ok    = (rem_shift >= trial);
  assign sum_total = window_sum + SUM_W'(root);

  assign avg          = prod[SHIFT +: LEVEL_W];
  assign diff         = (avg > level_held) ? (avg - level_held) : (level_held - avg);
  assign level_update = (diff > cfg.deadband);
  assign step_hit     = level_update && (avg > threshold_value) && (avg < level_held)
                        && (refractory_left == '0);
  assign wsu_inc      = windows_since_update + 1'b1;

  assign new_max = (level_held > level_max) ? level_held : level_max;
  assign new_min = (level_held < level_min) ? level_held : level_min;
  assign mid_sum = {1'b0, new_max} + {1'b0, new_min};

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      axis_sel             <= '0;
      root_cnt             <= '0;
      window_sum           <= '0;
      window_index         <= '0;
      level_held           <= '0;
      level_max            <= '0;
      level_min            <= '1;
      threshold_value      <= '0;
      refractory_left      <= '0;
      windows_since_update <= '0;
      step_counter         <= '0;
      step_now             <= 1'b0;
      window_done          <= 1'b0;
      track_due            <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            step_now    <= 1'b0;
            window_done <= 1'b0;
            if (q_item.opcode == OP_TICK) begin
              if (refractory_left != '0) begin
                refractory_left <= refractory_left - 1'b1;
              end
              state <= ST_OUT;
            end else begin
              axis_sel <= '0;
              state    <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          axis_sel <= axis_sel + 1'b1;
          if (axis_sel == 2'd2) begin
            root_cnt <= '0;
            state    <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          root_cnt <= root_cnt + 1'b1;
          if (root_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (window_index == IDX_W'(WINDOW - 1)) begin
            window_sum   <= '0;
            window_index <= '0;
            window_done  <= 1'b1;
            state        <= ST_LEVEL;
          end else begin
            window_sum   <= sum_total;
            window_index <= window_index + 1'b1;
            state        <= ST_OUT;
          end
        end
        ST_LEVEL: begin
          if (level_update) begin
            level_held <= avg;
          end
          if (step_hit) begin
            step_now        <= 1'b1;
            step_counter    <= step_counter + 1'b1;
            refractory_left <= cfg.refractory_ticks;
          end
          track_due <= (wsu_inc >= cfg.update_period);
          if (wsu_inc >= cfg.update_period) begin
            windows_since_update <= '0;
          end else begin
            windows_since_update <= wsu_inc;
          end
          state <= ST_TRACK;
        end
        ST_TRACK: begin
          if (track_due) begin
            level_max <= new_max;
            level_min <= new_min;
            if ((level_held > level_max) || (level_held < level_min)) begin
              threshold_value <= mid_sum[LEVEL_W:1];
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ax_x <= q_item.accel_x;
        ax_y <= q_item.accel_y;
        ax_z <= q_item.accel_z;
        rad  <= '0;
      end
      ST_SQUARE: begin
        rad  <= rad + RAD_W'($unsigned(square));
        rem  <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        rad  <= rad << 2;
        rem  <= rem_ok ? (rem_shift - trial) : rem_shift;
        root <= {root[LEVEL_W-2:0], rem_ok};
      end
      ST_SUM: begin
        prod <= PROD_W'(sum_total) * PROD_W'(RECIP);
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  assign q_ready = (state == ST_IDLE);
  assign cnt_ext = 32'(step_counter);

  assign results.valid          = (state == ST_OUT);
  assign results.step_total     = cnt_ext[TOTAL_W-1:0];
  assign results.step_now       = step_now;
  assign results.window_done    = window_done;
  assign results.held_level     = level_held;
  assign results.step_threshold = threshold_value;

endmodule

`default_nettype wire

/* hw/rtl/accel_step_counter_unit.sv */
// step counter top level: configuration registers, input queue and executor
// a tick beat goes straight from idle to output; a sample beat passes the square,
//   root and sum states, and the level and track states when it closes a window
// the executor takes one beat at a time, paced by the 13-step bit-serial root and
//   the shared squarer, and holds output until ready; two beats queue while busy
// reset: synchronous, clears all counters and levels, minimum to all ones,
//   registers to deadband 100, refractory 200 ticks, update period 51
`default_nettype none

module accel_step_counter_unit #(
  parameter int WINDOW     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [asc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]   cfg_data,
  asc_sample_if.sink                       samples,
  asc_result_if.source                     results
);
  import asc_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband         <= DEADBAND_RESET;
      cfg.refractory_ticks <= REFRACTORY_RESET;
      cfg.update_period    <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEADBAND:   cfg.deadband         <= cfg_data[DEADBAND_W-1:0];
        CFG_REFRACTORY: cfg.refractory_ticks <= cfg_data[REFR_W-1:0];
        CFG_PERIOD:     cfg.update_period    <= cfg_data[PERIOD_W-1:0];
        default:        cfg                  <= cfg;
      endcase
    end
  end

  asc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  asc_back #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .results (results)
  );

endmodule

`default_nettype wire
